[design/ptsg_pkg.sv]
// shared widths, codes and the counter record of the pulse train safety gate
// no dependencies; every other design file imports this package
package ptsg_pkg;

   localparam int BYTE_COUNT_BITS = 17;
   localparam int DATA_W          = 8;
   localparam int BIT_CNT_W       = 4;
   localparam int CNT_W           = 20;
   localparam int LEN_W           = 17;
   localparam int DUTY_W          = 7;
   localparam int RUN_LIM_W       = 16;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 17;
   localparam int VERDICT_W       = 2;

   localparam int DUTY_SCALE      = 100;
   localparam int DUTY_SCALE_W    = 7;
   localparam int BITS_PER_BYTE_SHIFT = 3;

   localparam int LEN_CMP_W = (BYTE_COUNT_BITS > LEN_W) ? BYTE_COUNT_BITS : LEN_W;
   localparam int ONES_PROD_W  = CNT_W + DUTY_SCALE_W;
   localparam int LIMIT_PROD_W = DUTY_W + BITS_PER_BYTE_SHIFT + BYTE_COUNT_BITS;
   localparam int PROD_W = (ONES_PROD_W > LIMIT_PROD_W) ? ONES_PROD_W : LIMIT_PROD_W;

   localparam logic [CNT_W-1:0]           CNT_MAX   = {CNT_W{1'b1}};
   localparam logic [BYTE_COUNT_BITS-1:0] BYTES_MAX = {BYTE_COUNT_BITS{1'b1}};

   localparam logic [LEN_W-1:0]     LENGTH_LIMIT_RESET = LEN_W'(50000);
   localparam logic [DUTY_W-1:0]    DUTY_LIMIT_RESET   = DUTY_W'(60);
   localparam logic [RUN_LIM_W-1:0] RUN_LIMIT_RESET    = RUN_LIM_W'(200);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CHECK_MODE   = 2'd0,
      CSR_LENGTH_LIMIT = 2'd1,
      CSR_DUTY_LIMIT   = 2'd2,
      CSR_RUN_LIMIT    = 2'd3
   } csr_index_type;

   typedef enum logic [VERDICT_W-1:0] {
      VERDICT_PASS     = 2'd0,
      VERDICT_TOO_LONG = 2'd1,
      VERDICT_DUTY     = 2'd2,
      VERDICT_RUN      = 2'd3
   } verdict_type;

   typedef struct packed {
      logic [BYTE_COUNT_BITS-1:0] bytes;
      logic [CNT_W-1:0]           ones;
      logic [CNT_W-1:0]           run_now;
      logic [CNT_W-1:0]           run_best;
   } counters_type;

endpackage

[design/ptsg_if.sv]
// request and response channels of the pulse train safety gate
// depends on ptsg_pkg for payload widths
interface ptsg_req_if;
   import ptsg_pkg::*;

   logic                valid;
   logic                ready;
   logic [DATA_W-1:0]   data_byte;
   logic                last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ptsg_rsp_if;
   import ptsg_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [VERDICT_W-1:0] verdict;
   logic [CNT_W-1:0]     ones_counted;
   logic [CNT_W-1:0]     longest_high_run;

   modport source (output valid, output verdict, output ones_counted,
                   output longest_high_run, input ready);
   modport sink   (input valid, input verdict, input ones_counted,
                   input longest_high_run, output ready);
endinterface

[design/ptsg_fold.sv]
// folds one pattern byte, lsb first, into the running saturating counters
// depends on ptsg_pkg for the counter record and widths
module ptsg_fold (
   input  logic [ptsg_pkg::DATA_W-1:0] data_byte,
   input  ptsg_pkg::counters_type      count_now,
   output ptsg_pkg::counters_type      count_next
);
   import ptsg_pkg::*;

   logic [BIT_CNT_W-1:0] pop;
   logic [BIT_CNT_W-1:0] low_ones;
   logic [BIT_CNT_W-1:0] high_ones;
   logic [BIT_CNT_W-1:0] inner_best;
   logic [BIT_CNT_W-1:0] inner_run;
   logic                 low_open;
   logic                 high_open;
   logic [CNT_W:0]       run_sum;
   logic [CNT_W-1:0]     run_ext;
   logic [CNT_W:0]       ones_sum;
   logic [CNT_W-1:0]     best_tmp;

   always_comb begin
      pop        = '0;
      low_ones   = '0;
      high_ones  = '0;
      inner_best = '0;
      inner_run  = '0;
      low_open   = 1'b1;
      high_open  = 1'b1;
      for (int k = 0; k < DATA_W; k++) begin
         if (data_byte[k]) begin
            pop       = pop + 1'b1;
            inner_run = inner_run + 1'b1;
            if (inner_run > inner_best) begin
               inner_best = inner_run;
            end
            if (low_open) begin
               low_ones = low_ones + 1'b1;
            end
         end else begin
            inner_run = '0;
            low_open  = 1'b0;
         end
         if (data_byte[DATA_W-1-k] && high_open) begin
            high_ones = high_ones + 1'b1;
         end else begin
            high_open = 1'b0;
         end
      end

      // run carried in from earlier bytes plus the low end of this one
      run_sum = {1'b0, count_now.run_now} + (CNT_W+1)'(low_ones);
      run_ext = run_sum[CNT_W] ? CNT_MAX : run_sum[CNT_W-1:0];

      ones_sum = {1'b0, count_now.ones} + (CNT_W+1)'(pop);

      best_tmp = count_now.run_best;
      if (run_ext > best_tmp) begin
         best_tmp = run_ext;
      end
      if (CNT_W'(inner_best) > best_tmp) begin
         best_tmp = CNT_W'(inner_best);
      end

      count_next.bytes    = (count_now.bytes == BYTES_MAX) ? BYTES_MAX
                                                           : count_now.bytes + 1'b1;
      count_next.ones     = ones_sum[CNT_W] ? CNT_MAX : ones_sum[CNT_W-1:0];
      count_next.run_now  = (&data_byte) ? run_ext : CNT_W'(high_ones);
      count_next.run_best = best_tmp;
   end

endmodule

[design/pulse_train_safety_gate.sv]
// pulse train safety gate: one pattern byte per cycle while ready is high, one verdict per buffer
// a finished buffer's totals go to the verdict stage register, then to the response register
// ready drops while the verdict stage holds a buffer that the stalled response register cannot take
// reset: synchronous, clears counters and pipeline valid bits, limits go to 50000 / 60 / 200
// depends on ptsg_pkg, ptsg_if and ptsg_fold
module pulse_train_safety_gate (
   input  logic                                clock,
   input  logic                                reset,
   ptsg_req_if.sink                            req_chan,
   ptsg_rsp_if.source                          rsp_chan,
   input  logic                                csr_write_enable,
   input  logic [ptsg_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ptsg_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import ptsg_pkg::*;

   logic                  check_mode_ff;
   logic [LEN_W-1:0]      length_limit_ff;
   logic [DUTY_W-1:0]     duty_limit_ff;
   logic [RUN_LIM_W-1:0]  run_limit_ff;

   counters_type          count_ff, count_in, count_fold;
   logic                  stage_valid_ff, stage_valid_in;
   counters_type          stage_count_ff, stage_count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   verdict_type           rsp_verdict_ff, rsp_verdict_in;
   logic [CNT_W-1:0]      rsp_ones_ff, rsp_ones_in;
   logic [CNT_W-1:0]      rsp_best_ff, rsp_best_in;

   logic                  out_free;
   logic                  stage_free;
   logic                  req_accept;
   logic                  run_bad;
   logic                  too_long;
   logic                  duty_bad;
   logic [PROD_W-1:0]     ones_scaled;
   logic [PROD_W-1:0]     limit_scaled;
   verdict_type           verdict;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign stage_free     = !stage_valid_ff || out_free;
   assign req_chan.ready = stage_free;
   assign req_accept     = req_chan.valid && stage_free;

   ptsg_fold u_fold (
      .data_byte  (req_chan.data_byte),
      .count_now  (count_ff),
      .count_next (count_fold)
   );

   // verdict on the captured totals of a finished buffer
   always_comb begin
      run_bad      = CNT_W'(run_limit_ff) <= stage_count_ff.run_best;
      too_long     = LEN_CMP_W'(stage_count_ff.bytes) > LEN_CMP_W'(length_limit_ff);
      ones_scaled  = PROD_W'(stage_count_ff.ones) * PROD_W'(DUTY_SCALE);
      limit_scaled = (PROD_W'(duty_limit_ff) * PROD_W'(stage_count_ff.bytes))
                     << BITS_PER_BYTE_SHIFT;
      duty_bad     = ones_scaled >= limit_scaled;
      if (check_mode_ff) begin
         verdict = run_bad ? VERDICT_RUN : VERDICT_PASS;
      end else if (too_long) begin
         verdict = VERDICT_TOO_LONG;
      end else if (duty_bad) begin
         verdict = VERDICT_DUTY;
      end else begin
         verdict = run_bad ? VERDICT_RUN : VERDICT_PASS;
      end
   end

   always_comb begin
      count_in       = count_ff;
      stage_valid_in = stage_valid_ff;
      stage_count_in = stage_count_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_ones_in    = rsp_ones_ff;
      rsp_best_in    = rsp_best_ff;

      if (out_free) begin
         rsp_valid_in   = stage_valid_ff;
         rsp_verdict_in = verdict;
         rsp_ones_in    = stage_count_ff.ones;
         rsp_best_in    = stage_count_ff.run_best;
      end
      if (stage_free) begin
         stage_valid_in = req_accept && req_chan.last_byte;
      end
      if (req_accept) begin
         if (req_chan.last_byte) begin
            stage_count_in = count_fold;
            count_in       = '0;
         end else begin
            count_in = count_fold;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         check_mode_ff   <= 1'b0;
         length_limit_ff <= LENGTH_LIMIT_RESET;
         duty_limit_ff   <= DUTY_LIMIT_RESET;
         run_limit_ff    <= RUN_LIMIT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_CHECK_MODE:   check_mode_ff   <= csr_write_data[0];
            CSR_LENGTH_LIMIT: length_limit_ff <= csr_write_data[LEN_W-1:0];
            CSR_DUTY_LIMIT:   duty_limit_ff   <= csr_write_data[DUTY_W-1:0];
            CSR_RUN_LIMIT:    run_limit_ff    <= csr_write_data[RUN_LIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         count_ff       <= count_in;
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_count_ff <= stage_count_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_ones_ff    <= rsp_ones_in;
      rsp_best_ff    <= rsp_best_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.verdict          = rsp_verdict_ff;
   assign rsp_chan.ones_counted     = rsp_ones_ff;
   assign rsp_chan.longest_high_run = rsp_best_ff;

   // last byte lands in the verdict stage
   a_last_to_stage: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_chan.last_byte |=> stage_valid_ff)
      else $error("last byte did not reach the verdict stage");

   // counters start over after a verdict
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_chan.last_byte |=> count_ff == '0)
      else $error("counters not cleared after last byte");

   // longest run covers the open run
   a_best_covers_now: assert property (@(posedge clock) disable iff (reset)
      count_ff.run_best >= count_ff.run_now)
      else $error("longest run below current run");

   // no run can exceed the ones counted
   a_ones_cover_best: assert property (@(posedge clock) disable iff (reset)
      count_ff.ones >= count_ff.run_best)
      else $error("longest run exceeds ones count");

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// self-checking bench for pulse_train_safety_gate: queued pattern bytes, a
// per-byte fold that predicts each buffer verdict, and a response scoreboard
// depends on ptsg_pkg, ptsg_if and the gate itself
module testbench;
   import ptsg_pkg::*;

   typedef struct {
      logic [DATA_W-1:0] data_byte;
      logic              last_byte;
   } pulse_request_type;

   typedef struct {
      verdict_type      verdict;
      logic [CNT_W-1:0] ones;
      logic [CNT_W-1:0] run;
   } gate_verdict_type;

   logic clock;
   logic reset = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   ptsg_req_if req_chan ();
   ptsg_rsp_if rsp_chan ();

   pulse_train_safety_gate uut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   pulse_request_type pending_requests[$];
   gate_verdict_type  expected_verdicts[$];
   int requests_queued    = 0;
   int requests_accepted  = 0;
   int error_count        = 0;
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int rsp_hold_request   = 0;
   int rsp_hold_left      = 0;
   bit req_taken          = 1'b0;

   // predicted gate state and limits
   logic                       cfg_run_only;
   logic [LEN_W-1:0]           cfg_length_limit;
   logic [DUTY_W-1:0]          cfg_duty_percent;
   logic [RUN_LIM_W-1:0]       cfg_run_limit;
   logic [BYTE_COUNT_BITS-1:0] seen_bytes;
   logic [CNT_W-1:0]           seen_ones;
   logic [CNT_W-1:0]           run_current;
   logic [CNT_W-1:0]           run_longest;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("[pulse_train_safety_gate] ERROR");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic fold_request(input logic [DATA_W-1:0] data, input logic last);
      gate_verdict_type got;
      logic             run_bad;
      longint unsigned  ones_scaled;
      longint unsigned  limit_scaled;
      if (seen_bytes != BYTES_MAX) seen_bytes++;
      for (int k = 0; k < DATA_W; k++) begin
         if (data[k]) begin
            if (seen_ones != CNT_MAX) seen_ones++;
            if (run_current != CNT_MAX) run_current++;
            if (run_current > run_longest) run_longest = run_current;
         end else begin
            run_current = '0;
         end
      end
      if (last) begin
         run_bad = (run_longest >= CNT_W'(cfg_run_limit));
         ones_scaled = 64'(seen_ones) * 64'(DUTY_SCALE);
         limit_scaled = 64'(cfg_duty_percent) * 64'(8) * 64'(seen_bytes);
         if (cfg_run_only) got.verdict = run_bad ? VERDICT_RUN : VERDICT_PASS;
         else if (seen_bytes > cfg_length_limit) got.verdict = VERDICT_TOO_LONG;
         else if (ones_scaled >= limit_scaled) got.verdict = VERDICT_DUTY;
         else got.verdict = run_bad ? VERDICT_RUN : VERDICT_PASS;
         got.ones = seen_ones;
         got.run = run_longest;
         expected_verdicts.push_back(got);
         seen_bytes = '0;
         seen_ones = '0;
         run_current = '0;
         run_longest = '0;
      end
   endtask

   always @(posedge clock) begin : watch_channels
      gate_verdict_type want;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            fold_request(req_chan.data_byte, req_chan.last_byte);
            requests_accepted++;
            req_taken = 1'b1;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch($sformatf("response with nothing expected, verdict %0d",
                                         rsp_chan.verdict));
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_chan.verdict !== want.verdict)
                  report_mismatch($sformatf("verdict %0d, expected %0d",
                                            rsp_chan.verdict, want.verdict));
               if (rsp_chan.ones_counted !== want.ones)
                  report_mismatch($sformatf("ones_counted %0d, expected %0d",
                                            rsp_chan.ones_counted, want.ones));
               if (rsp_chan.longest_high_run !== want.run)
                  report_mismatch($sformatf("longest_high_run %0d, expected %0d",
                                            rsp_chan.longest_high_run, want.run));
            end
         end
      end
   end

   always @(negedge clock) begin : drive_requests
      pulse_request_type next_req;
      if (!reset && (!req_chan.valid || req_taken)) begin
         if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            next_req = pending_requests.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.data_byte <= next_req.data_byte;
            req_chan.last_byte <= next_req.last_byte;
         end else begin
            req_chan.valid <= 1'b0;
            req_chan.data_byte <= DATA_W'($urandom);
            req_chan.last_byte <= 1'($urandom);
         end
      end
      req_taken = 1'b0;
   end

   always @(negedge clock) begin : drive_ready
      if (rsp_hold_request != 0) begin
         rsp_hold_left = rsp_hold_request;
         rsp_hold_request = 0;
      end
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (rsp_hold_left != 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_hold_left--;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] data;
      data = value;
      // junk above the register width, dropped by the gate
      case (idx)
         CSR_CHECK_MODE: begin
            data[CSR_DATA_W-1:1] = (CSR_DATA_W-1)'($urandom);
            cfg_run_only = data[0];
         end
         CSR_LENGTH_LIMIT: begin
            cfg_length_limit = data[LEN_W-1:0];
         end
         CSR_DUTY_LIMIT: begin
            data[CSR_DATA_W-1:DUTY_W] = (CSR_DATA_W-DUTY_W)'($urandom);
            cfg_duty_percent = data[DUTY_W-1:0];
         end
         default: begin
            data[CSR_DATA_W-1:RUN_LIM_W] = (CSR_DATA_W-RUN_LIM_W)'($urandom);
            cfg_run_limit = data[RUN_LIM_W-1:0];
         end
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      csr_index <= CSR_INDEX_W'($urandom);
      csr_write_data <= CSR_DATA_W'($urandom);
   endtask

   task automatic set_limits(input logic mode, input logic [LEN_W-1:0] len,
                             input logic [DUTY_W-1:0] duty, input logic [RUN_LIM_W-1:0] run);
      write_reg(CSR_CHECK_MODE, CSR_DATA_W'(mode));
      write_reg(CSR_LENGTH_LIMIT, CSR_DATA_W'(len));
      write_reg(CSR_DUTY_LIMIT, CSR_DATA_W'(duty));
      write_reg(CSR_RUN_LIMIT, CSR_DATA_W'(run));
   endtask

   task automatic random_limits();
      logic                 mode;
      logic [LEN_W-1:0]     len;
      logic [DUTY_W-1:0]    duty;
      logic [RUN_LIM_W-1:0] run;
      int                   pick;
      mode = ($urandom_range(3) == 0);
      pick = $urandom_range(9);
      if (pick < 5) len = LEN_W'($urandom_range(40, 1));
      else if (pick < 8) len = LEN_W'($urandom_range(100000, 1));
      else if (pick == 8) len = '0;
      else len = '1;
      pick = $urandom_range(9);
      if (pick < 6) duty = DUTY_W'($urandom_range(100, 1));
      else if (pick == 6) duty = DUTY_W'($urandom);
      else if (pick == 7) duty = '0;
      else if (pick == 8) duty = DUTY_W'(100);
      else duty = '1;
      pick = $urandom_range(9);
      if (pick < 6) run = RUN_LIM_W'($urandom_range(40, 1));
      else if (pick == 6) run = RUN_LIM_W'($urandom_range(65535, 1));
      else if (pick == 7) run = '0;
      else if (pick == 8) run = RUN_LIM_W'(1);
      else run = '1;
      set_limits(mode, len, duty, run);
   endtask

   task automatic queue_request(input logic [DATA_W-1:0] data, input logic last);
      pulse_request_type item;
      item.data_byte = data;
      item.last_byte = last;
      pending_requests.push_back(item);
      requests_queued++;
   endtask

   function automatic logic [DATA_W-1:0] pattern_byte();
      case ($urandom_range(9))
         0, 1, 2, 3: return DATA_W'($urandom);
         4, 5: return 8'hFF;
         6: return 8'h00;
         7: return 8'hFF << $urandom_range(7);
         8: return 8'hFF >> $urandom_range(7);
         default: return 8'h01 << $urandom_range(7);
      endcase
   endfunction

   task automatic queue_buffer(input int len);
      for (int i = 1; i <= len; i++) queue_request(pattern_byte(), i == len);
   endtask

   task automatic wait_for_idle();
      do @(negedge clock);
      while (requests_accepted != requests_queued || expected_verdicts.size() != 0);
      repeat (6) @(negedge clock);
   endtask

   task automatic random_phase(input int sender_pct, input int receiver_pct, input int count);
      int pick;
      int start;
      sender_idle_pct = sender_pct;
      receiver_stall_pct = receiver_pct;
      random_limits();
      start = requests_queued;
      while (requests_queued - start < count) begin
         pick = $urandom_range(99);
         if (pick < 70) queue_buffer($urandom_range(6, 1));
         else if (pick < 95) queue_buffer($urandom_range(30, 7));
         else queue_buffer($urandom_range(120, 31));
         if ($urandom_range(39) == 0) begin
            wait_for_idle();
            random_limits();
         end
      end
      wait_for_idle();
   endtask

   initial begin : stimulus
      req_chan.valid = 1'b0;
      req_chan.data_byte = '0;
      req_chan.last_byte = 1'b0;
      rsp_chan.ready = 1'b0;
      cfg_run_only = 1'b0;
      cfg_length_limit = LENGTH_LIMIT_RESET;
      cfg_duty_percent = DUTY_LIMIT_RESET;
      cfg_run_limit = RUN_LIMIT_RESET;
      seen_bytes = '0;
      seen_ones = '0;
      run_current = '0;
      run_longest = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // limits as left by reset
      queue_request(8'h00, 1'b1);
      queue_request(8'hFF, 1'b1);
      queue_request(8'h80, 1'b0);
      queue_request(8'h01, 1'b1);
      queue_request(8'h55, 1'b0);
      queue_request(8'hAA, 1'b1);
      wait_for_idle();

      // zero duty limit and a one-byte length limit
      set_limits(1'b0, LEN_W'(1), DUTY_W'(0), RUN_LIMIT_RESET);
      queue_request(8'h00, 1'b1);
      queue_request(8'h00, 1'b0);
      queue_request(8'h00, 1'b1);
      wait_for_idle();

      // run check only, zero and unit run limit
      set_limits(1'b1, LEN_W'(0), DUTY_W'(0), RUN_LIM_W'(0));
      queue_request(8'h00, 1'b1);
      wait_for_idle();
      write_reg(CSR_RUN_LIMIT, CSR_DATA_W'(1));
      queue_request(8'h00, 1'b1);
      queue_request(8'h01, 1'b1);
      wait_for_idle();

      // duty boundary and runs across bytes
      set_limits(1'b0, LEN_W'(100000), DUTY_W'(100), 16'hFFFF);
      queue_request(8'hFF, 1'b1);
      queue_request(8'hFE, 1'b1);
      wait_for_idle();
      set_limits(1'b0, 17'h1FFFF, 7'h7F, RUN_LIM_W'(9));
      queue_request(8'hFF, 1'b0);
      queue_request(8'h01, 1'b1);
      queue_request(8'hFF, 1'b0);
      queue_request(8'h00, 1'b1);
      queue_request(8'hC0, 1'b0);
      queue_request(8'hFF, 1'b0);
      queue_request(8'h00, 1'b1);
      wait_for_idle();

      random_phase(0, 0, 150);
      random_phase(84, 0, 150);
      random_phase(0, 84, 150);
      random_phase(19, 19, 150);

      // receiver held off while the sender keeps offering
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      random_limits();
      rsp_hold_request = 300;
      repeat (50) queue_buffer(1);
      wait_for_idle();

      if (error_count == 0) $display("[pulse_train_safety_gate] OK");
      else $display("[pulse_train_safety_gate] ERROR");
      $finish;
   end

endmodule
